FILE: sv/newton_unity_root_step_defines.svh
// ----------------------------------------------------------------------------
// Newton unity root step assertion macros
// Shared assertion shorthands; clk and rst are taken from the enclosing module.
// ----------------------------------------------------------------------------
`ifndef NEWTON_UNITY_ROOT_STEP_DEFINES_SVH
`define NEWTON_UNITY_ROOT_STEP_DEFINES_SVH

// same-cycle implication
`define NURS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define NURS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/nurs_pkg.sv
// ----------------------------------------------------------------------------
// nurs_pkg
// Types, codes and sign-magnitude helpers for the Newton unity root step.
// ----------------------------------------------------------------------------
package nurs_pkg;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } sm_t;

  localparam logic [1:0] ST_CONTINUE  = 2'd0;
  localparam logic [1:0] ST_CONVERGED = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam logic [1:0] BASIN_PLAIN  = 2'd0;
  localparam logic [1:0] BASIN_COLOUR = 2'd1;
  localparam logic [1:0] BASIN_STRIPE = 2'd2;

  localparam logic [2:0] REG_DEGREE       = 3'd0;
  localparam logic [2:0] REG_BASIN_MODE   = 3'd1;
  localparam logic [2:0] REG_THRESHOLD    = 3'd2;
  localparam logic [2:0] REG_RECIP_DEGREE = 3'd3;
  localparam logic [2:0] REG_DEGREE_RATIO = 3'd4;

  function automatic logic [31:0] mag32(input logic signed [31:0] x);
    return x[31] ? (~x + 32'd1) : x;
  endfunction

  function automatic logic [31:0] mag33(input logic signed [32:0] x);
    logic [32:0] m;
    m = x[32] ? (~x + 33'd1) : x;
    return m[31:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic signed [31:0] r;
    if (neg) begin
      r = (mag >= 64'h8000_0000) ? 32'sh8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      r = (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : mag[31:0];
    end
    return r;
  endfunction

  function automatic sm_t addx(input sm_t x, input sm_t y);
    sm_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 64'd0) r.neg = 1'b0;
    return r;
  endfunction

endpackage

FILE: sv/nurs_ram.sv
// ----------------------------------------------------------------------------
// nurs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nurs_ram #(
  parameter int WIDTH = 52,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/nurs_mul.sv
// ----------------------------------------------------------------------------
// nurs_mul
// Shared 32x32 unsigned magnitude multiplier, registered, signed result.
// ----------------------------------------------------------------------------
module nurs_mul (
  input  logic          clk,
  input  logic [31:0]   a,
  input  logic [31:0]   b,
  input  logic          neg,
  output nurs_pkg::sm_t prod
);

  import nurs_pkg::*;

  logic [63:0] p;

  assign p = a * b;

  always_ff @(posedge clk) begin
    prod.mag <= p;
    prod.neg <= neg && (p != 64'd0);
  end

endmodule

FILE: sv/nurs_div.sv
// ----------------------------------------------------------------------------
// nurs_div
// Restoring radix-2 divider: (mag << FRAC_BITS) / den, saturated to 32 bits.
// ----------------------------------------------------------------------------
module nurs_div #(
  parameter int FRAC_BITS = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  nurs_pkg::sm_t      num,
  input  logic [63:0]        den,
  output logic               busy,
  output logic               done,
  output logic signed [31:0] quo
);

  import nurs_pkg::*;

  localparam int DVW = 64 + FRAC_BITS;
  localparam int CW  = $clog2(DVW + 1);

  logic [DVW-1:0] dvd;
  logic [63:0]    rem;
  logic [31:0]    q;
  logic           ovf;
  logic           neg;
  logic [CW-1:0]  cnt;
  logic [64:0]    rem_sh;
  logic [64:0]    rem_sub;
  logic           ge;

  assign rem_sh  = {rem, dvd[DVW-1]};
  assign ge      = rem_sh >= {1'b0, den};
  assign rem_sub = rem_sh - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {num.mag, {FRAC_BITS{1'b0}}};
      rem <= '0;
      q   <= '0;
      ovf <= 1'b0;
      neg <= num.neg;
    end else if (busy) begin
      dvd <= {dvd[DVW-2:0], 1'b0};
      rem <= ge ? rem_sub[63:0] : rem_sh[63:0];
      q   <= {q[30:0], ge};
      ovf <= ovf | q[31];
    end
  end

  // a one shifted past bit 31 means the quotient saturates
  assign quo = sat32(neg, ovf ? 64'hFFFF_FFFF_FFFF_FFFF : {32'd0, q});

endmodule

FILE: sv/newton_unity_root_step.sv
// ----------------------------------------------------------------------------
// newton_unity_root_step
// One Newton step for z^n - 1 in Q8.24, root table load, basin colouring.
// ----------------------------------------------------------------------------
// Paths from accept to result valid:
//   load transaction: no result, table written at the accept edge.
//   converged: power loop and threshold check, plus root walk in basin mode.
//   continue: power loop, check, |t|^2, u, u*conj(t), two divider runs.
// Throughput: one transaction at a time; in_stall is high until the result
// sits in the output register. Reset (rst, synchronous) restores the register
// defaults and idles the sequencer; the root table is not cleared.
// ----------------------------------------------------------------------------
`include "newton_unity_root_step_defines.svh"

module newton_unity_root_step #(
  parameter int MAX_DEGREE = 16,
  parameter int FRAC_BITS  = 24
) (
  input  logic               clk,
  input  logic               rst,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic signed [31:0] z_re,
  input  logic signed [31:0] z_im,
  input  logic               iter_parity,
  input  logic [3:0]         root_index,
  input  logic signed [25:0] root_re,
  input  logic signed [25:0] root_im,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] next_re,
  output logic signed [31:0] next_im,
  output logic [1:0]         status,
  output logic [4:0]         colour,
  // register write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  import nurs_pkg::*;

  localparam int NW = $clog2(MAX_DEGREE + 1);
  localparam int AW = $clog2(MAX_DEGREE);
  localparam int DW = 65 - FRAC_BITS;   // width of a squared-distance sum
  localparam logic signed [32:0] ONE = 33'(64'd1 << FRAC_BITS);

  // one-hot sequencer
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_POW  = 10'b00_0000_0010,  // t = z^(n-1), w = t*z
    S_CHK  = 10'b00_0000_0100,  // |w-1|^2 vs threshold
    S_ROOT = 10'b00_0000_1000,  // basin search over root table
    S_DEN  = 10'b00_0001_0000,  // |t|^2
    S_UR   = 10'b00_0010_0000,  // u = ratio*w + 1/n
    S_NUM  = 10'b00_0100_0000,  // u * conj(t)
    S_DIVR = 10'b00_1000_0000,
    S_DIVI = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000   // wait for output register
  } state_t;

  // configuration registers
  logic [4:0]  degree;
  logic [1:0]  basin_mode;
  logic [30:0] threshold;
  logic [24:0] recip_degree;
  logic [24:0] degree_ratio;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      degree       <= 5'd3;
      basin_mode   <= BASIN_PLAIN;
      threshold    <= 31'd5270718;
      recip_degree <= 25'd5592405;
      degree_ratio <= 25'd11184811;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEGREE:       degree       <= cfg_data[4:0];
        REG_BASIN_MODE:   basin_mode   <= cfg_data[1:0];
        REG_THRESHOLD:    threshold    <= cfg_data[30:0];
        REG_RECIP_DEGREE: recip_degree <= cfg_data[24:0];
        REG_DEGREE_RATIO: degree_ratio <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // control
  state_t        state, state_next;
  logic [2:0]    ph, ph_next;
  logic [NW-1:0] k, k_next;
  logic          out_valid_next;
  logic          in_acc;
  logic          out_load;

  // datapath
  logic signed [31:0] zr, zi, tr, ti, wr, wi, cr_tmp, ur, ui, nr, ni;
  logic               par;
  logic [NW-1:0]      n_eff, n_in;
  sm_t                acc, numr, numi, sumx, prod;
  logic [DW-1:0]      dsum, dpart, dtot;
  logic [63:0]        den, den_sum;
  logic [1:0]         st;
  logic [4:0]         col, col_hit;
  logic               below;
  logic signed [31:0] scaled, scaled_sum, ur_clamp;
  logic signed [33:0] ur_sum;
  logic signed [32:0] wm1, dre, dim;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic        mul_neg;

  // root table
  logic          wr_en, rd_en;
  logic [51:0]   rd_data;
  logic [NW:0]   kp1;

  // divider
  logic               div_start, div_busy, div_done;
  logic signed [31:0] div_quo;
  sm_t                div_num;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_load = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    if (degree < 5'd2) begin
      n_in = NW'(2);
    end else if (32'(degree) > MAX_DEGREE) begin
      n_in = NW'(MAX_DEGREE);
    end else begin
      n_in = NW'(degree);
    end
  end

  // entries at or above MAX_DEGREE are dropped
  assign wr_en = in_acc && !action && (32'(root_index) < MAX_DEGREE);
  assign rd_en = (state == S_ROOT) && (ph == 3'd0);

  nurs_ram #(.WIDTH(52), .DEPTH(MAX_DEGREE)) u_roots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(root_index)),
    .wr_data ({root_re, root_im}),
    .rd_en   (rd_en),
    .rd_addr (k[AW-1:0]),
    .rd_data (rd_data)
  );

  assign wm1 = {wr[31], wr} - ONE;
  assign dre = {{7{rd_data[51]}}, rd_data[51:26]} - {zr[31], zr};
  assign dim = {{7{rd_data[25]}}, rd_data[25:0]} - {zi[31], zi};

  // operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state)
      S_POW: begin
        case (ph)
          3'd0: begin mul_a = mag32(tr); mul_b = mag32(zr); mul_neg = tr[31] ^ zr[31]; end
          3'd1: begin mul_a = mag32(ti); mul_b = mag32(zi); mul_neg = ~(ti[31] ^ zi[31]); end
          3'd2: begin mul_a = mag32(tr); mul_b = mag32(zi); mul_neg = tr[31] ^ zi[31]; end
          3'd3: begin mul_a = mag32(ti); mul_b = mag32(zr); mul_neg = ti[31] ^ zr[31]; end
          default: ;
        endcase
      end
      S_CHK: begin
        if (ph == 3'd0) begin
          mul_a = mag33(wm1); mul_b = mag33(wm1);
        end else begin
          mul_a = mag32(wi); mul_b = mag32(wi);
        end
      end
      S_ROOT: begin
        if (ph == 3'd1) begin
          mul_a = mag33(dre); mul_b = mag33(dre);
        end else begin
          mul_a = mag33(dim); mul_b = mag33(dim);
        end
      end
      S_DEN: begin
        if (ph == 3'd0) begin
          mul_a = mag32(tr); mul_b = mag32(tr);
        end else begin
          mul_a = mag32(ti); mul_b = mag32(ti);
        end
      end
      S_UR: begin
        if (ph == 3'd0) begin
          mul_a = {7'd0, degree_ratio}; mul_b = mag32(wr); mul_neg = wr[31];
        end else begin
          mul_a = mag32(wi); mul_b = {7'd0, degree_ratio}; mul_neg = wi[31];
        end
      end
      S_NUM: begin
        case (ph)
          3'd0: begin mul_a = mag32(ur); mul_b = mag32(tr); mul_neg = ur[31] ^ tr[31]; end
          3'd1: begin mul_a = mag32(ui); mul_b = mag32(ti); mul_neg = ui[31] ^ ti[31]; end
          3'd2: begin mul_a = mag32(ui); mul_b = mag32(tr); mul_neg = ui[31] ^ tr[31]; end
          3'd3: begin mul_a = mag32(ur); mul_b = mag32(ti); mul_neg = ~(ur[31] ^ ti[31]); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  nurs_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .neg  (mul_neg),
    .prod (prod)
  );

  // product post-processing
  assign sumx       = addx(acc, prod);
  assign scaled     = sat32(prod.neg, prod.mag >> FRAC_BITS);
  assign scaled_sum = sat32(sumx.neg, sumx.mag >> FRAC_BITS);
  assign dpart      = DW'(prod.mag >> FRAC_BITS);
  assign dtot       = dsum + dpart;
  assign below      = dtot < DW'(threshold);
  assign den_sum    = acc.mag + prod.mag;
  assign ur_sum     = {{2{scaled[31]}}, scaled} + 34'(recip_degree);

  always_comb begin
    if (ur_sum > 34'sh0_7FFF_FFFF) begin
      ur_clamp = 32'sh7FFF_FFFF;
    end else if (ur_sum < -34'sh0_8000_0000) begin
      ur_clamp = 32'sh8000_0000;
    end else begin
      ur_clamp = ur_sum[31:0];
    end
  end

  // basin colour of root k
  assign kp1 = {1'b0, k} + 1'b1;
  always_comb begin
    if (basin_mode == BASIN_STRIPE) begin
      col_hit = {1'b0, par, 3'd0} + {2'd0, 3'(k)} + 5'd1;
    end else begin
      col_hit = 5'(kp1);
    end
  end

  // divider
  assign div_start = ((state == S_NUM) && (ph == 3'd4)) || ((state == S_DIVR) && div_done);
  assign div_num   = (state == S_NUM) ? numr : numi;

  nurs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    ph_next        = ph + 3'd1;
    k_next         = k;
    out_valid_next = (out_valid && out_stall) || out_load;
    case (state)
      S_IDLE: begin
        ph_next = 3'd0;
        if (in_acc && action) begin
          state_next = S_POW;
          k_next     = NW'(2);
        end
      end
      S_POW: begin
        if (ph == 3'd4) begin
          ph_next = 3'd0;
          if (k < n_eff) begin
            k_next = k + 1'b1;
          end else begin
            state_next = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (ph == 3'd2) begin
          ph_next = 3'd0;
          if (below) begin
            k_next = '0;
            if (basin_mode == BASIN_COLOUR || basin_mode == BASIN_STRIPE) begin
              state_next = S_ROOT;
            end else begin
              state_next = S_FIN;
            end
          end else begin
            state_next = S_DEN;
          end
        end
      end
      S_ROOT: begin
        if (ph == 3'd3) begin
          ph_next = 3'd0;
          if (below || (kp1 == {1'b0, n_eff})) begin
            state_next = S_FIN;
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      S_DEN: begin
        if (ph == 3'd2) begin
          ph_next    = 3'd0;
          state_next = (den_sum == 64'd0) ? S_FIN : S_UR;
        end
      end
      S_UR: begin
        if (ph == 3'd2) begin
          ph_next    = 3'd0;
          state_next = S_NUM;
        end
      end
      S_NUM: begin
        if (ph == 3'd4) begin
          ph_next    = 3'd0;
          state_next = S_DIVR;
        end
      end
      S_DIVR: begin
        ph_next = 3'd0;
        if (div_done) state_next = S_DIVI;
      end
      S_DIVI: begin
        ph_next = 3'd0;
        if (div_done) state_next = S_FIN;
      end
      S_FIN: begin
        ph_next = 3'd0;
        if (out_load) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
        ph_next    = 3'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ph        <= 3'd0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ph        <= ph_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_acc && action) begin
          zr    <= z_re;
          zi    <= z_im;
          tr    <= z_re;
          ti    <= z_im;
          par   <= iter_parity;
          n_eff <= n_in;
        end
      end
      S_POW: begin
        case (ph)
          3'd1, 3'd3: acc <= prod;
          3'd2:       cr_tmp <= scaled_sum;
          3'd4: begin
            if (k < n_eff) begin
              tr <= cr_tmp;
              ti <= scaled_sum;
            end else begin
              wr <= cr_tmp;
              wi <= scaled_sum;
            end
          end
          default: ;
        endcase
      end
      S_CHK: begin
        if (ph == 3'd1) dsum <= dpart;
        if (ph == 3'd2) begin
          st  <= ST_CONVERGED;
          nr  <= wr;
          ni  <= wi;
          col <= 5'd0;
        end
      end
      S_ROOT: begin
        if (ph == 3'd2) dsum <= dpart;
        if (ph == 3'd3 && below) col <= col_hit;
      end
      S_DEN: begin
        if (ph == 3'd1) acc <= prod;
        if (ph == 3'd2) begin
          den <= den_sum;
          st  <= ST_UNDERFLOW;
          nr  <= zr;
          ni  <= zi;
          col <= 5'd0;
        end
      end
      S_UR: begin
        if (ph == 3'd1) ur <= ur_clamp;
        if (ph == 3'd2) ui <= scaled;
      end
      S_NUM: begin
        case (ph)
          3'd1, 3'd3: acc <= prod;
          3'd2:       numr <= sumx;
          3'd4:       numi <= sumx;
          default: ;
        endcase
      end
      S_DIVR: begin
        if (div_done) nr <= div_quo;
      end
      S_DIVI: begin
        if (div_done) begin
          ni  <= div_quo;
          st  <= ST_CONTINUE;
          col <= 5'd0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      next_re <= nr;
      next_im <= ni;
      status  <= st;
      colour  <= col;
    end
  end

  `NURS_ASSERT_NXT(a_iter_start, in_acc && action, state == S_POW && k == NW'(2),
    "iterate transaction did not start the power loop")
  `NURS_ASSERT_IMP(a_colour_conv, out_valid && colour != 5'd0, status == ST_CONVERGED,
    "colour set on a result that did not converge")
  `NURS_ASSERT_IMP(a_div_free, div_start, !div_busy,
    "divider started while busy")
  `NURS_ASSERT_IMP(a_root_range, rd_en, k < n_eff,
    "root walk past the clamped degree")

endmodule

FILE: tb/sv/newton_unity_root_step_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// newton_unity_root_step_tb
// Drives root table loads and Newton iterations through the block across
// several register settings. A local Q8.24 model predicts every result, and
// each received transaction is checked field by field against it.
// ----------------------------------------------------------------------------
module newton_unity_root_step_tb;
  import nurs_pkg::*;

  localparam int  FRAC       = 24;
  localparam int  TBL_DEPTH  = 16;
  localparam int  LIMIT      = 1200000;
  // longest busy time: degree 16 plus the divider, rounded up well
  localparam int  DRAIN_WAIT = 400;
  localparam int  HOLD_LEN   = 300;
  localparam longint ONE     = 64'sd1 << FRAC;

  typedef struct {
    bit                action;
    bit signed [31:0]  zr;
    bit signed [31:0]  zi;
    bit                parity;
    bit [3:0]          idx;
    bit signed [25:0]  rr;
    bit signed [25:0]  ri;
  } step_item_t;

  typedef struct {
    bit signed [31:0] re;
    bit signed [31:0] im;
    bit [1:0]         st;
    bit [4:0]         col;
  } step_result_t;

  typedef struct {
    bit        neg;
    bit [63:0] mag;
  } signed_mag_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = 1'b0;
  logic signed [31:0] z_re = '0;
  logic signed [31:0] z_im = '0;
  logic               iter_parity = 1'b0;
  logic [3:0]         root_index = '0;
  logic signed [25:0] root_re = '0;
  logic signed [25:0] root_im = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] next_re;
  logic signed [31:0] next_im;
  logic [1:0]         status;
  logic [4:0]         colour;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  newton_unity_root_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .action(action),
    .z_re(z_re), .z_im(z_im), .iter_parity(iter_parity),
    .root_index(root_index), .root_re(root_re), .root_im(root_im),
    .out_valid(out_valid), .out_stall(out_stall),
    .next_re(next_re), .next_im(next_im), .status(status), .colour(colour),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // local copy of the block's registers and root table
  bit [4:0]  m_degree    = 5'd3;
  bit [1:0]  m_basin     = BASIN_PLAIN;
  bit [30:0] m_thresh    = 31'd5270718;
  bit [24:0] m_recip     = 25'd5592405;
  bit [24:0] m_ratio     = 25'd11184811;
  longint    root_tbl_re [TBL_DEPTH];
  longint    root_tbl_im [TBL_DEPTH];

  step_item_t   pending_steps[$];
  step_result_t expected_steps[$];

  int  send_idle  = 0;   // percent of cycles the sender idles
  int  recv_stall = 0;   // percent of cycles the receiver stalls
  bit  hold_req   = 1'b0;
  int  hold_left  = 0;
  bit  in_acc     = 1'b0;
  bit  cfg_acc    = 1'b0;
  int  errors     = 0;
  int  cycles     = 0;
  int  n_loads = 0, n_iters = 0, n_conv = 0, n_under = 0, n_cont = 0, n_col = 0;

  // --------------------------------------------------------------------------
  // Fixed point helpers: exact products in sign-magnitude, truncate, saturate
  // --------------------------------------------------------------------------
  function automatic bit [63:0] magof(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic signed_mag_t smul(longint a, longint b);
    signed_mag_t r;
    r.mag = magof(a) * magof(b);
    r.neg = ((a < 0) != (b < 0)) && (r.mag != 0);
    return r;
  endfunction

  function automatic signed_mag_t sneg(signed_mag_t x);
    x.neg = !x.neg && (x.mag != 0);
    return x;
  endfunction

  function automatic signed_mag_t ssum(signed_mag_t x, signed_mag_t y);
    signed_mag_t r;
    if (x.neg == y.neg) begin
      r.mag = x.mag + y.mag;
      r.neg = x.neg;
    end else if (x.mag >= y.mag) begin
      r.mag = x.mag - y.mag;
      r.neg = x.neg;
    end else begin
      r.mag = y.mag - x.mag;
      r.neg = y.neg;
    end
    if (r.mag == 0) r.neg = 1'b0;
    return r;
  endfunction

  function automatic longint clip32(bit neg, bit [63:0] mag);
    if (neg) return (mag >= 64'h8000_0000) ? -64'sd2147483648 : -longint'(mag);
    return (mag > 64'h7FFF_FFFF) ? 64'sd2147483647 : longint'(mag);
  endfunction

  function automatic longint descale(signed_mag_t x);
    return clip32(x.neg, x.mag >> FRAC);
  endfunction

  function automatic bit [63:0] dist2(longint d);
    bit [63:0] m;
    m = magof(d);
    return (m * m) >> FRAC;
  endfunction

  // (num << FRAC) / den, truncated; anything past 33 bits saturates anyway
  function automatic longint fx_divide(signed_mag_t num, bit [63:0] den);
    bit [127:0] wide;
    bit [127:0] q;
    bit [63:0]  qm;
    wide = {64'd0, num.mag} << FRAC;
    q    = wide / {64'd0, den};
    qm   = (q >= (128'd1 << 33)) ? (64'd1 << 40) : q[63:0];
    return clip32(num.neg, qm);
  endfunction

  function automatic int eff_degree(bit [4:0] d);
    if (d < 2) return 2;
    if (d > TBL_DEPTH) return TBL_DEPTH;
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Newton step model: returns 1 when the transaction yields a result
  // --------------------------------------------------------------------------
  function automatic bit newton_predict(step_item_t it, output step_result_t res);
    longint zr, zi, tr, ti, wr, wi, nr, ni, ur, ui, prev_r;
    int n;
    bit [63:0] den;
    signed_mag_t numr, numi;
    res = '{default: 0};
    if (!it.action) begin
      root_tbl_re[it.idx] = it.rr;
      root_tbl_im[it.idx] = it.ri;
      n_loads++;
      return 1'b0;
    end
    n_iters++;
    zr = it.zr;
    zi = it.zi;
    n  = eff_degree(m_degree);
    tr = zr;
    ti = zi;
    for (int k = 2; k < n; k++) begin
      prev_r = tr;
      tr = descale(ssum(smul(prev_r, zr), sneg(smul(ti, zi))));
      ti = descale(ssum(smul(prev_r, zi), smul(ti, zr)));
    end
    wr = descale(ssum(smul(tr, zr), sneg(smul(ti, zi))));
    wi = descale(ssum(smul(tr, zi), smul(ti, zr)));
    if (dist2(wr - ONE) + dist2(wi) < {33'd0, m_thresh}) begin
      res.st = ST_CONVERGED;
      nr = wr;
      ni = wi;
      n_conv++;
      if (m_basin == BASIN_COLOUR || m_basin == BASIN_STRIPE) begin
        for (int k = 0; k < n; k++) begin
          if (dist2(root_tbl_re[k] - zr) + dist2(root_tbl_im[k] - zi)
              < {33'd0, m_thresh}) begin
            res.col = (m_basin == BASIN_STRIPE) ? 5'(1 + (k & 7) + (it.parity << 3))
                                                : 5'(1 + k);
            n_col++;
            break;
          end
        end
      end
    end else begin
      den = magof(tr) * magof(tr) + magof(ti) * magof(ti);
      if (den == 0) begin
        res.st = ST_UNDERFLOW;
        nr = zr;
        ni = zi;
        n_under++;
      end else begin
        res.st = ST_CONTINUE;
        ur = descale(smul(longint'(m_ratio), wr)) + longint'(m_recip);
        if (ur > 64'sd2147483647) ur = 64'sd2147483647;
        if (ur < -64'sd2147483648) ur = -64'sd2147483648;
        ui = descale(smul(wi, longint'(m_ratio)));
        numr = ssum(smul(ur, tr), smul(ui, ti));
        numi = ssum(smul(ui, tr), sneg(smul(ur, ti)));
        nr = fx_divide(numr, den);
        ni = fx_divide(numi, den);
        n_cont++;
      end
    end
    res.re = nr[31:0];
    res.im = ni[31:0];
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, cycle limit
  // --------------------------------------------------------------------------
  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles", $time, cycles);
      $display("newton_unity_root_step_tb: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Accept side: predict on every input transaction, track register writes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    step_item_t   it;
    step_result_t res;
    in_acc  <= !rst && in_valid && !in_stall;
    cfg_acc <= !rst && cfg_valid && cfg_ready;
    if (!rst && in_valid && !in_stall) begin
      it = '{action, z_re, z_im, iter_parity, root_index, root_re, root_im};
      if (newton_predict(it, res)) expected_steps.push_back(res);
    end
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEGREE:       m_degree <= cfg_data[4:0];
        REG_BASIN_MODE:   m_basin  <= cfg_data[1:0];
        REG_THRESHOLD:    m_thresh <= cfg_data[30:0];
        REG_RECIP_DEGREE: m_recip  <= cfg_data[24:0];
        REG_DEGREE_RATIO: m_ratio  <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // Driver: a new payload only once the previous one was taken
  always @(negedge clk) begin
    step_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (pending_steps.size() > 0 && $urandom_range(99) >= send_idle) begin
        it = pending_steps.pop_front();
        action      <= it.action;
        z_re        <= it.zr;
        z_im        <= it.zi;
        iter_parity <= it.parity;
        root_index  <= it.idx;
        root_re     <= it.rr;
        root_im     <= it.ri;
        in_valid    <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_LEN;
      hold_req  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall);
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    step_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        errors++;
        $display("%0t unexpected result re=%h im=%h st=%0d col=%0d",
                 $time, next_re, next_im, status, colour);
      end else begin
        exp_r = expected_steps.pop_front();
        if (next_re !== exp_r.re || next_im !== exp_r.im ||
            status !== exp_r.st || colour !== exp_r.col) begin
          errors++;
          $display("%0t mismatch: expected re=%h im=%h st=%0d col=%0d, actual re=%h im=%h st=%0d col=%0d",
                   $time, exp_r.re, exp_r.im, exp_r.st, exp_r.col,
                   next_re, next_im, status, colour);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(negedge clk); while (!cfg_acc);
    cfg_valid <= 1'b0;
  endtask

  function automatic longint unity_coord(int k, int n, bit imag);
    real a;
    longint v;
    a = 6.283185307179586 * k / n;
    v = $rtoi((imag ? $sin(a) : $cos(a)) * 16777216.0 + (imag ? 0.0 : 0.0));
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    return v;
  endfunction

  function automatic step_item_t mk_iter(longint zr, longint zi, bit par);
    step_item_t it;
    it.action = 1'b1;
    it.zr     = zr[31:0];
    it.zi     = zi[31:0];
    it.parity = par;
    it.idx    = 4'($urandom);
    it.rr     = 26'($urandom);
    it.ri     = 26'($urandom);
    return it;
  endfunction

  function automatic step_item_t mk_load(int idx, longint rr, longint ri);
    step_item_t it;
    it.action = 1'b0;
    it.zr     = $urandom;
    it.zi     = $urandom;
    it.parity = 1'($urandom);
    it.idx    = idx[3:0];
    it.rr     = rr[25:0];
    it.ri     = ri[25:0];
    return it;
  endfunction

  // Mostly points near a root (well formed), then wide noise and zeros
  task automatic queue_random(int count, int n);
    int sel, k;
    longint spread;
    repeat (count) begin
      sel = $urandom_range(99);
      k   = $urandom_range(n - 1);
      case ($urandom_range(2))
        0: spread = 64'sd1 << 12;
        1: spread = 64'sd1 << 20;
        default: spread = 64'sd1 << 23;
      endcase
      if (sel < 12) begin
        if ($urandom_range(1))
          pending_steps.push_back(mk_load($urandom_range(15), unity_coord(k, n, 0),
                                          unity_coord(k, n, 1)));
        else
          pending_steps.push_back(mk_load($urandom_range(15),
                                          longint'($urandom_range(1 << 25)) - ONE,
                                          longint'($urandom_range(1 << 25)) - ONE));
      end else if (sel < 62) begin
        pending_steps.push_back(mk_iter(
          unity_coord(k, n, 0) + longint'($urandom_range(2 * spread)) - spread,
          unity_coord(k, n, 1) + longint'($urandom_range(2 * spread)) - spread,
          1'($urandom)));
      end else if (sel < 70) begin
        pending_steps.push_back(mk_iter(longint'($urandom_range(8)) - 4,
                                        longint'($urandom_range(8)) - 4, 1'($urandom)));
      end else if (sel < 85) begin
        pending_steps.push_back(mk_iter(longint'($urandom_range(1 << 26)) - (1 << 25),
                                        longint'($urandom_range(1 << 26)) - (1 << 25),
                                        1'($urandom)));
      end else begin
        pending_steps.push_back(mk_iter(longint'($signed($urandom)),
                                        longint'($signed($urandom)), 1'($urandom)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_steps.size() != 0 || in_valid || expected_steps.size() != 0);
    // loads leave no result behind, so give the block time to go quiet
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic run_phase(bit wr_regs, int deg, int mode, int thr, int rcp, int rto,
                           int count, int s_idle, int r_stall, bit hold, bit directed);
    int n;
    if (wr_regs) begin
      write_reg(REG_DEGREE, deg);
      write_reg(REG_BASIN_MODE, mode);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_RECIP_DEGREE, rcp);
      write_reg(REG_DEGREE_RATIO, rto);
    end
    send_idle  = s_idle;
    recv_stall = r_stall;
    n = eff_degree(deg[4:0]);
    // fill the whole table so every basin search reads written entries
    for (int i = 0; i < TBL_DEPTH; i++)
      pending_steps.push_back(mk_load(i, unity_coord(i % n, n, 0), unity_coord(i % n, n, 1)));
    if (directed) begin
      pending_steps.push_back(mk_iter(64'sd2147483647, 64'sd2147483647, 1'b0));
      pending_steps.push_back(mk_iter(-64'sd2147483648, -64'sd2147483648, 1'b1));
      pending_steps.push_back(mk_iter(64'sd2147483647, -64'sd2147483648, 1'b0));
      pending_steps.push_back(mk_iter(0, 0, 1'b0));           // t is zero
      pending_steps.push_back(mk_iter(1, -1, 1'b1));          // t truncates to zero
      pending_steps.push_back(mk_iter(ONE, 0, 1'b1));         // exact root
      pending_steps.push_back(mk_iter(-ONE, 0, 1'b0));
      pending_steps.push_back(mk_iter(ONE + 4096, -4096, 1'b1));
      pending_steps.push_back(mk_iter(0, ONE, 1'b0));
      pending_steps.push_back(mk_iter(ONE >> 1, ONE >> 1, 1'b1));
      pending_steps.push_back(mk_load(15, ONE, -ONE));
      pending_steps.push_back(mk_load(14, -ONE, ONE));
      pending_steps.push_back(mk_iter(3 * ONE, -5 * ONE, 1'b0));
    end
    if (hold) hold_req = 1'b1;
    queue_random(count, n);
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // reset defaults, directed corners first
    run_phase(0, 3, 0, 5270718, 5592405, 11184811, 60, 24, 58, 0, 1);
    run_phase(1, 2, BASIN_COLOUR, 5270718, 1 << 23, 1 << 23, 80, 24, 58, 1, 0);
    run_phase(1, 16, BASIN_STRIPE, 32'h7FFF_FFFF, 1048576, 15728640, 70, 24, 58, 0, 0);
    run_phase(1, 5, BASIN_STRIPE, 0, 3355443, 13421773, 70, 58, 24, 0, 0);
    run_phase(1, 0, 3, 1 << 22, 0, 1 << 24, 70, 58, 24, 0, 0);
    run_phase(1, 31, BASIN_COLOUR, 5270718, 1 << 24, 0, 70, 58, 24, 0, 0);
    run_phase(1, 7, BASIN_COLOUR, 1 << 23, 2396745, 14380471, 45, 0, 0, 0, 0);
    run_phase(1, 4, BASIN_STRIPE, 5270718, 4194304, 12582912, 45, 0, 0, 0, 0);

    if (expected_steps.size() != 0) begin
      errors++;
      $display("%0t %0d predicted results never arrived", $time, expected_steps.size());
    end
    $display("covered %0d iterations and %0d table loads over 8 register settings",
             n_iters, n_loads);
    $display("outcomes: %0d continue, %0d converged (%0d coloured), %0d underflow",
             n_cont, n_conv, n_col, n_under);
    if (errors == 0) begin
      $display("newton_unity_root_step_tb: done, clean");
    end else begin
      $display("newton_unity_root_step_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/nurs_pkg.sv
sv/nurs_ram.sv
sv/nurs_mul.sv
sv/nurs_div.sv
sv/newton_unity_root_step.sv
tb/sv/newton_unity_root_step_tb.sv
